FILE: hw/rtl/ldbpd_pkg.sv
// Package for the LED data beacon pattern drive: frame layout, time constants,
// reciprocal constants for the constant dividers, code types and bit helpers.
// No dependencies.
package ldbpd_pkg;

	localparam int unsigned PAYLOAD_LEN  = 16;
	localparam int unsigned PREAMBLE_LEN = 10;
	localparam int unsigned CALIB_SLOTS  = 10;
	localparam int unsigned SLOT_US      = 8333;

	localparam int unsigned TS_W       = 32;
	localparam int unsigned PAYLOAD_W  = 16;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned SLOT_IDX_W = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 16'd51862;

	localparam int unsigned SYNC_LEN = 10;
	localparam logic [SYNC_LEN-1:0] SYNC_WORD = 10'b0100110110;

	localparam int unsigned PAY_USED = (PAYLOAD_LEN < PAYLOAD_W) ? PAYLOAD_LEN : PAYLOAD_W;

	localparam int unsigned FRAME_SLOTS = PREAMBLE_LEN + 2 * (2 + PAYLOAD_LEN);
	localparam longint unsigned FRAME_US  = longint'(SLOT_US) * FRAME_SLOTS;
	localparam longint unsigned CALIB_US  = longint'(SLOT_US) * CALIB_SLOTS;
	localparam longint unsigned WIN_US    = CALIB_US + FRAME_US;
	localparam longint unsigned SEC_US    = 1000000;
	localparam longint unsigned HALF_US   = SEC_US / 2;
	localparam longint unsigned HALF3_US  = 3 * HALF_US;
	localparam longint unsigned PERIOD_US = 2 * SEC_US;

	// timestamp reduction: estimate quotient by floor reciprocal, fix with one subtract
	localparam longint unsigned MOD_MAX = (FRAME_US > PERIOD_US) ? FRAME_US : PERIOD_US;
	localparam longint unsigned MIN_DIV = (FRAME_US < SEC_US) ? FRAME_US : SEC_US;
	localparam int unsigned TP_W = $clog2(MOD_MAX + 1);
	localparam longint unsigned RM_FRAME  = (64'd1 << TS_W) / FRAME_US;
	localparam longint unsigned RM_SEC    = (64'd1 << TS_W) / SEC_US;
	localparam longint unsigned RM_PERIOD = (64'd1 << TS_W) / PERIOD_US;
	localparam longint unsigned RM_MAX    = (64'd1 << TS_W) / MIN_DIV;
	localparam int unsigned RM_W = $clog2(RM_MAX + 1);

	// slot number: exact ceiling reciprocal over the offset range
	localparam longint unsigned OFF_MAX = (FRAME_US > CALIB_US) ? FRAME_US : CALIB_US;
	localparam int unsigned OFF_W = $clog2(OFF_MAX + 1);
	localparam int unsigned K_S   = $clog2(OFF_MAX * SLOT_US);
	localparam longint unsigned M_S = ((64'd1 << K_S) + SLOT_US - 1) / SLOT_US;
	localparam int unsigned MS_W  = $clog2(M_S + 1);
	localparam int unsigned SP_W  = OFF_W + MS_W;
	localparam int unsigned SLOT_MAX = (FRAME_SLOTS > CALIB_SLOTS) ? FRAME_SLOTS : CALIB_SLOTS;
	localparam int unsigned SLOT_W = $clog2(SLOT_MAX);

	// breathing brightness: 255 * ramp / PERIOD_US, exact ceiling reciprocal
	localparam int unsigned RAMP_W = $clog2(SEC_US + 1);
	localparam longint unsigned NB_MAX = 255 * SEC_US;
	localparam int unsigned NB_W  = $clog2(NB_MAX + 1);
	localparam int unsigned K_B   = $clog2((NB_MAX + 1) * PERIOD_US);
	localparam longint unsigned M_B = ((64'd1 << K_B) + PERIOD_US - 1) / PERIOD_US;
	localparam int unsigned MB_W  = $clog2(M_B + 1);
	localparam int unsigned BP_W  = NB_W + MB_W;

	typedef enum logic [1:0] {
		MODE_FRAMES     = 2'd0,
		MODE_FAST_BLINK = 2'd1,
		MODE_SLOW_BLINK = 2'd2,
		MODE_BREATH     = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CALIB  = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_STEADY = 2'd2,
		KIND_DARK   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_MODE  = 2'd0,
		REG_PAYLOAD_BITS  = 2'd1,
		REG_SUPPRESS_DATA = 2'd2,
		REG_OUTPUT_ENABLE = 2'd3
	} reg_idx_t;

	function automatic logic [PREAMBLE_LEN-1:0] preamble_table();
		logic [PREAMBLE_LEN-1:0] tbl;
		tbl = '0;
		for (int i = 0; i < PREAMBLE_LEN; i++) begin
			tbl[i] = SYNC_WORD[i % SYNC_LEN];
		end
		return tbl;
	endfunction

	localparam logic [PREAMBLE_LEN-1:0] PREAMBLE_TBL = preamble_table();

	// line bit of a frame slot: preamble, two parity symbols, payload symbols
	function automatic logic frame_bit(input logic [SLOT_W-1:0] slot,
			input logic [PAYLOAD_W-1:0] payload);
		logic [SLOT_W-1:0] j;
		logic [SLOT_W-2:0] sym;
		logic par0;
		logic par1;
		logic b;
		j = slot - SLOT_W'(PREAMBLE_LEN);
		sym = j[SLOT_W-1:1];
		par0 = 1'b0;
		par1 = 1'b0;
		b = 1'b0;
		for (int k = 0; k < PAY_USED; k++) begin
			if ((k & 1) == 0) begin
				par0 = par0 ^ payload[k];
			end else begin
				par1 = par1 ^ payload[k];
			end
		end
		if (slot < SLOT_W'(PREAMBLE_LEN)) begin
			for (int i = 0; i < PREAMBLE_LEN; i++) begin
				if (slot == SLOT_W'(i)) begin
					b = PREAMBLE_TBL[i];
				end
			end
		end else begin
			if (sym == '0) begin
				b = par0;
			end else if (sym == (SLOT_W-1)'(1)) begin
				b = par1;
			end else begin
				for (int k = 0; k < PAY_USED; k++) begin
					if (int'(sym) == k + 2) begin
						b = payload[k];
					end
				end
			end
			b = b ^ j[0];
		end
		return b;
	endfunction

	// x / 3 for x below 512
	function automatic logic [7:0] div3(input logic [8:0] x);
		logic [18:0] p;
		p = x * 10'd683;
		return p[18:11];
	endfunction

endpackage

FILE: hw/rtl/led_data_beacon_pattern_drive_top.sv
// LED data beacon pattern drive, top level. Depends on ldbpd_pkg.
// Each request carries a microsecond timestamp and yields one result: the LED PWM
// level, the segment kind, the slot number and the line bit for that instant. The
// block is a nine-stage pipeline with a valid bit per stage: a request can enter every
// cycle while the output does not stall, and passes through the chain of reciprocal
// multiplications that reduce the timestamp to a period position, then to a slot
// number and a brightness. A stalled output holds its stage while free stages
// upstream keep filling. Configuration registers are shared by all requests in flight:
// a write reaches each request at the stages that it has not yet passed.
module led_data_beacon_pattern_drive_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ldbpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ldbpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ldbpd_pkg::TS_W-1:0]         elapsed_us,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ldbpd_pkg::LEVEL_W-1:0]      led_level,
	output logic [ldbpd_pkg::KIND_W-1:0]       segment_kind,
	output logic [ldbpd_pkg::SLOT_IDX_W-1:0]   slot_index,
	output logic                               coded_bit
);
	import ldbpd_pkg::*;

	localparam int NSTG = 9;

	mode_t                 mode_q;
	logic [PAYLOAD_W-1:0]  payload_q;
	logic                  suppress_q;
	logic                  enable_q;

	logic [NSTG+1:1]       adv;
	logic [NSTG:1]         vld_q;
	logic [NSTG:1]         vld_prev;

	logic [TS_W-1:0]       t_s1, t_s2, t_s3;
	logic [RM_W-1:0]       rm_sel;
	logic [TP_W-1:0]       div_sel;
	logic [TS_W+RM_W-1:0]  q_prod;
	logic [RM_W-1:0]       q_s2;
	logic [RM_W+TP_W-1:0]  qc_full, qc_s3;
	logic [TS_W-1:0]       rem_full;
	logic [TP_W:0]         rem;
	logic [TP_W-1:0]       tp_next, tp_s4;
	logic [TP_W-1:0]       tw_next, tw_s5, tw_frame, ramp_dn;
	logic [RAMP_W-1:0]     ramp_next, ramp_s5;
	logic                  dark_next, dark_s5;
	kind_t                 kind_next, kind_s6, kind_s7, kind_s8, kind_s9;
	logic [OFF_W-1:0]      off_next, off_s6;
	logic [NB_W-1:0]       nb_next, nb_s6;
	logic [SP_W-1:0]       sprod_s7;
	logic [BP_W-1:0]       bprod_s7;
	logic [SLOT_W-1:0]     slot_next, slot_s8;
	logic                  bit_next, bit_s8, bit_s9;
	logic [LEVEL_W-1:0]    bright_next, bright_s8;
	logic [LEVEL_W-1:0]    level_next, level_s9;
	logic [SLOT_IDX_W-1:0] slot_s9;
	logic [LEVEL_W-1:0]    one3, two3, half3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_FRAMES;
			payload_q  <= PAYLOAD_RESET;
			suppress_q <= 1'b0;
			enable_q   <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PATTERN_MODE:  mode_q <= mode_t'(cfg_wdata[1:0]);
				REG_PAYLOAD_BITS:  payload_q <= cfg_wdata[PAYLOAD_W-1:0];
				REG_SUPPRESS_DATA: suppress_q <= cfg_wdata[0];
				REG_OUTPUT_ENABLE: enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		adv[NSTG+1] = out_ready;
		for (int i = NSTG; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign vld_prev  = {vld_q[NSTG-1:1], in_valid};
	assign in_ready  = adv[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NSTG; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_prev[i];
				end
			end
		end
	end

	always_comb begin
		case (mode_q)
			MODE_FRAMES: begin
				rm_sel  = RM_W'(RM_FRAME);
				div_sel = TP_W'(FRAME_US);
			end
			MODE_FAST_BLINK: begin
				rm_sel  = RM_W'(RM_SEC);
				div_sel = TP_W'(SEC_US);
			end
			default: begin
				rm_sel  = RM_W'(RM_PERIOD);
				div_sel = TP_W'(PERIOD_US);
			end
		endcase
	end

	// period position
	assign q_prod   = t_s1 * rm_sel;
	assign qc_full  = q_s2 * div_sel;
	assign rem_full = t_s3 - TS_W'(qc_s3);
	assign rem      = rem_full[TP_W:0];
	assign tp_next  = (rem >= {1'b0, div_sel}) ? TP_W'(rem - {1'b0, div_sel}) : rem[TP_W-1:0];

	// window offset, dark half and ramp position
	assign ramp_dn = TP_W'(PERIOD_US) - tp_s4;

	always_comb begin
		tw_next = tp_s4;
		if (mode_q == MODE_SLOW_BLINK || mode_q == MODE_BREATH) begin
			if (tp_s4 >= TP_W'(HALF3_US)) begin
				tw_next = tp_s4 - TP_W'(HALF3_US);
			end else if (tp_s4 >= TP_W'(SEC_US)) begin
				tw_next = tp_s4 - TP_W'(SEC_US);
			end else if (tp_s4 >= TP_W'(HALF_US)) begin
				tw_next = tp_s4 - TP_W'(HALF_US);
			end
		end
		case (mode_q)
			MODE_FAST_BLINK: dark_next = (tp_s4 >= WIN_US) && (tp_s4 >= HALF_US);
			MODE_SLOW_BLINK: dark_next = (tp_s4 >= SEC_US);
			default:         dark_next = 1'b0;
		endcase
		if (tp_s4 < SEC_US) begin
			ramp_next = tp_s4[RAMP_W-1:0];
		end else begin
			ramp_next = ramp_dn[RAMP_W-1:0];
		end
	end

	// segment kind and offset within it
	assign tw_frame = tw_s5 - TP_W'(CALIB_US);
	assign nb_next  = NB_W'({ramp_s5, 8'h00}) - NB_W'(ramp_s5);

	always_comb begin
		kind_next = KIND_STEADY;
		off_next  = '0;
		if (mode_q == MODE_FRAMES) begin
			kind_next = KIND_FRAME;
			off_next  = OFF_W'(tw_s5);
		end else if (dark_s5) begin
			kind_next = KIND_DARK;
		end else if (tw_s5 < CALIB_US) begin
			kind_next = KIND_CALIB;
			off_next  = OFF_W'(tw_s5);
		end else if (tw_s5 < WIN_US) begin
			kind_next = KIND_FRAME;
			off_next  = OFF_W'(tw_frame);
		end
	end

	// slot number, line bit and brightness
	always_comb begin
		slot_next = SLOT_W'(sprod_s7 >> K_S);
		case (kind_s7)
			KIND_CALIB: bit_next = slot_next[0];
			KIND_FRAME: bit_next = frame_bit(slot_next, payload_q);
			default:    bit_next = 1'b0;
		endcase
		if (mode_q == MODE_BREATH) begin
			bright_next = LEVEL_W'(bprod_s7 >> K_B);
		end else if (kind_s7 == KIND_DARK) begin
			bright_next = '0;
		end else begin
			bright_next = 8'd255;
		end
	end

	// output level
	assign one3  = div3({1'b0, bright_s8});
	assign two3  = div3({bright_s8, 1'b0});
	assign half3 = div3({2'b00, bright_s8[7:1]});

	always_comb begin
		if (!enable_q) begin
			level_next = '0;
		end else if (kind_s8 == KIND_STEADY || kind_s8 == KIND_DARK || suppress_q) begin
			level_next = half3 + two3;
		end else if (bit_s8) begin
			level_next = one3 + two3;
		end else begin
			level_next = two3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			t_s1 <= elapsed_us;
		end
		if (adv[2]) begin
			t_s2 <= t_s1;
			q_s2 <= q_prod[TS_W+RM_W-1:TS_W];
		end
		if (adv[3]) begin
			t_s3  <= t_s2;
			qc_s3 <= qc_full;
		end
		if (adv[4]) begin
			tp_s4 <= tp_next;
		end
		if (adv[5]) begin
			tw_s5   <= tw_next;
			ramp_s5 <= ramp_next;
			dark_s5 <= dark_next;
		end
		if (adv[6]) begin
			kind_s6 <= kind_next;
			off_s6  <= off_next;
			nb_s6   <= nb_next;
		end
		if (adv[7]) begin
			kind_s7  <= kind_s6;
			sprod_s7 <= off_s6 * MS_W'(M_S);
			bprod_s7 <= nb_s6 * MB_W'(M_B);
		end
		if (adv[8]) begin
			kind_s8   <= kind_s7;
			slot_s8   <= slot_next;
			bit_s8    <= bit_next;
			bright_s8 <= bright_next;
		end
		if (adv[9]) begin
			kind_s9  <= kind_s8;
			slot_s9  <= SLOT_IDX_W'(slot_s8);
			bit_s9   <= bit_s8;
			level_s9 <= level_next;
		end
	end

	assign led_level    = level_s9;
	assign segment_kind = kind_s9;
	assign slot_index   = slot_s9;
	assign coded_bit    = bit_s9;

endmodule

FILE: bench/tb_led_data_beacon_pattern_drive_top.sv
// Self-checking bench for led_data_beacon_pattern_drive_top: random timestamps,
// random idle cycles on both sides, results scored in order against a local predictor.
// Depends on ldbpd_pkg and the top-level RTL.
module tb_led_data_beacon_pattern_drive_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ldbpd_pkg::*;

	localparam longint unsigned SLOT_SPAN = 8333;
	localparam longint unsigned CAL_SPAN = SLOT_SPAN * 10;
	localparam longint unsigned FRM_SPAN = SLOT_SPAN * 46;
	localparam longint unsigned WIN_SPAN = CAL_SPAN + FRM_SPAN;
	localparam longint unsigned SECOND = 1000000;
	localparam longint unsigned HALF_SEC = SECOND / 2;
	localparam logic [0:9] SYNC_SEQ = 10'b0110110010;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_ITEMS = 100;

	typedef struct {
		logic [LEVEL_W-1:0] level;
		kind_t kind;
		logic [SLOT_IDX_W-1:0] slot;
		logic line_bit;
	} beacon_result_t;

	class beacon_level_board;
		mode_t mode;
		logic [PAYLOAD_W-1:0] payload;
		logic suppress;
		logic enable;
		beacon_result_t pending_levels[$];
		int unsigned stamps_seen;
		int unsigned results_checked;
		int unsigned errors;
		int unsigned per_mode[4];

		function new();
			mode = MODE_FRAMES;
			payload = PAYLOAD_RESET;
			suppress = 1'b0;
			enable = 1'b1;
			stamps_seen = 0;
			results_checked = 0;
			errors = 0;
			foreach (per_mode[i]) per_mode[i] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_PATTERN_MODE: mode = mode_t'(v[1:0]);
				REG_PAYLOAD_BITS: payload = v[PAYLOAD_W-1:0];
				REG_SUPPRESS_DATA: suppress = v[0];
				REG_OUTPUT_ENABLE: enable = v[0];
				default: ;
			endcase
		endfunction

		function logic frame_line_bit(int unsigned s);
			int unsigned j;
			int unsigned sym;
			logic b;
			if (s < 10) return SYNC_SEQ[s];
			j = s - 10;
			sym = j >> 1;
			b = 1'b0;
			if (sym < 2) begin
				for (int k = sym; k < 16; k += 2) b ^= payload[k];
			end else begin
				b = payload[sym-2];
			end
			return b ^ j[0];
		endfunction

		function beacon_result_t beacon_level_of(logic [TS_W-1:0] ts);
			beacon_result_t r;
			longint unsigned t;
			longint unsigned tp;
			longint unsigned tw;
			int unsigned brt;
			int unsigned slot_n;
			logic in_win;
			r.kind = KIND_STEADY;
			r.line_bit = 1'b0;
			slot_n = 0;
			brt = 255;
			in_win = 1'b0;
			tw = 0;
			t = 64'(ts);
			case (mode)
				MODE_FRAMES: begin
					r.kind = KIND_FRAME;
					slot_n = 32'((t % FRM_SPAN) / SLOT_SPAN);
					r.line_bit = frame_line_bit(slot_n);
				end
				MODE_FAST_BLINK: begin
					tp = t % SECOND;
					if (tp < WIN_SPAN) begin
						in_win = 1'b1;
						tw = tp;
					end else if (tp >= HALF_SEC) begin
						r.kind = KIND_DARK;
						brt = 0;
					end
				end
				MODE_SLOW_BLINK: begin
					tp = t % (2 * SECOND);
					if (tp < SECOND) begin
						in_win = 1'b1;
						tw = tp % HALF_SEC;
					end else begin
						r.kind = KIND_DARK;
						brt = 0;
					end
				end
				default: begin
					tp = t % (2 * SECOND);
					if (tp < SECOND) brt = 32'(255 * tp / SECOND / 2);
					else brt = 32'(255 * (2 * SECOND - tp) / SECOND / 2);
					in_win = 1'b1;
					tw = tp % HALF_SEC;
				end
			endcase
			if (in_win) begin
				if (tw < CAL_SPAN) begin
					r.kind = KIND_CALIB;
					slot_n = 32'(tw / SLOT_SPAN);
					r.line_bit = slot_n[0];
				end else if (tw < WIN_SPAN) begin
					r.kind = KIND_FRAME;
					slot_n = 32'((tw - CAL_SPAN) / SLOT_SPAN);
					r.line_bit = frame_line_bit(slot_n);
				end
			end
			r.slot = slot_n[SLOT_IDX_W-1:0];
			if (!enable) r.level = '0;
			else if (r.kind == KIND_STEADY || r.kind == KIND_DARK || suppress)
				r.level = LEVEL_W'(brt / 2 / 3 + 2 * brt / 3);
			else
				r.level = LEVEL_W'(brt * r.line_bit / 3 + 2 * brt / 3);
			return r;
		endfunction

		function void note_stamp(logic [TS_W-1:0] ts);
			pending_levels.insert(pending_levels.size(), beacon_level_of(ts));
			stamps_seen++;
			per_mode[mode]++;
		endfunction

		function void check_level(logic [LEVEL_W-1:0] level, logic [KIND_W-1:0] kind,
				logic [SLOT_IDX_W-1:0] slot, logic line_bit);
			beacon_result_t e;
			if (pending_levels.size() == 0) begin
				$display("%0t: unexpected result level %0d kind %0d slot %0d bit %0d",
					$time, level, kind, slot, line_bit);
				errors++;
				return;
			end
			e = pending_levels.pop_front();
			results_checked++;
			if (e.level !== level || e.kind !== kind || e.slot !== slot
					|| e.line_bit !== line_bit) begin
				$display("%0t: mismatch: expected level %0d kind %0d slot %0d bit %0d,",
					$time, e.level, e.kind, e.slot, e.line_bit);
				$display("%0t:           actual   level %0d kind %0d slot %0d bit %0d",
					$time, level, kind, slot, line_bit);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_levels.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [TS_W-1:0] elapsed_us;
	logic out_valid;
	logic out_ready;
	logic [LEVEL_W-1:0] led_level;
	logic [KIND_W-1:0] segment_kind;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic coded_bit;

	beacon_level_board board;
	int unsigned max_gap;
	int unsigned cycles;

	led_data_beacon_pattern_drive_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.elapsed_us(elapsed_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_level(led_level),
		.segment_kind(segment_kind),
		.slot_index(slot_index),
		.coded_bit(coded_bit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL led_data_beacon_pattern_drive_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.note_stamp(elapsed_us);
			if (out_valid && out_ready)
				board.check_level(led_level, segment_kind, slot_index, coded_bit);
		end
	end

	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, max_gap);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	task automatic send_stamp(input logic [TS_W-1:0] ts);
		int unsigned gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		elapsed_us <= ts;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.outstanding() > 0) @(negedge clk);
	endtask

	task automatic configure(input mode_t m, input logic [PAYLOAD_W-1:0] pay,
			input logic sup, input logic en);
		logic [CFG_DATA_W-1:0] vals[4];
		vals[0] = CFG_DATA_W'(m);
		vals[1] = pay;
		vals[2] = CFG_DATA_W'(sup);
		vals[3] = CFG_DATA_W'(en);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_wdata <= vals[i];
			@(negedge clk);
			board.set_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [TS_W-1:0] corner_stamps[4][6];
		logic [TS_W-1:0] ts;
		longint unsigned base;
		mode_t m;
		logic [PAYLOAD_W-1:0] pay;
		board = new();
		cycles = 0;
		max_gap = 13;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		elapsed_us = '0;
		corner_stamps = '{
			'{32'd0, 32'd8332, 32'd8333, TS_W'(FRM_SPAN - 1), TS_W'(FRM_SPAN), 32'hFFFFFFFF},
			'{32'd0, TS_W'(WIN_SPAN - 1), TS_W'(WIN_SPAN), TS_W'(HALF_SEC - 1),
				TS_W'(HALF_SEC), TS_W'(SECOND - 1)},
			'{TS_W'(CAL_SPAN - 1), TS_W'(CAL_SPAN), TS_W'(HALF_SEC + WIN_SPAN),
				TS_W'(SECOND - 1), TS_W'(SECOND), TS_W'(2 * SECOND - 1)},
			'{32'd0, TS_W'(HALF_SEC + WIN_SPAN), TS_W'(SECOND - 1), TS_W'(SECOND),
				TS_W'(3 * HALF_SEC + CAL_SPAN), 32'hFFFFFFFF}
		};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings first, then each mode at the corner timestamps
		for (int md = 0; md < 4; md++) begin
			if (md > 0) begin
				drain();
				configure(mode_t'(md), PAYLOAD_RESET, 1'b0, 1'b1);
			end
			for (int i = 0; i < 6; i++) send_stamp(corner_stamps[md][i]);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			m = mode_t'(p % 4);
			pay = (p == 0) ? '0 : (p == 1) ? '1 : PAYLOAD_W'($urandom);
			configure(m, pay, (p % 3 == 2), (p % 5 != 4));
			max_gap = (p % 6 == 5) ? 0 : 13;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && p % 4 == 1) drain();
				case ($urandom_range(0, 4))
					0: ts = $urandom;
					1: ts = 32'hFFFFFFFF - $urandom_range(0, 3000000);
					2: begin
						base = longint'($urandom_range(0, 2147)) * 2 * SECOND;
						ts = TS_W'(base + $urandom_range(0, 2 * SECOND - 1));
					end
					3: begin
						base = longint'($urandom_range(0, 2147)) * 2 * SECOND
							+ $urandom_range(0, 3) * HALF_SEC;
						if ($urandom_range(0, 3) == 0) base += WIN_SPAN;
						else base += $urandom_range(0, 56) * SLOT_SPAN;
						ts = TS_W'(base + $urandom_range(0, 2) - 1);
					end
					default: begin
						base = longint'($urandom_range(0, 11204)) * FRM_SPAN
							+ $urandom_range(0, 46) * SLOT_SPAN;
						ts = TS_W'(base + $urandom_range(0, 2) - 1);
					end
				endcase
				send_stamp(ts);
			end
		end

		drain();
		repeat (30) @(negedge clk);
		$display("Checked %0d results for %0d timestamps; per mode %0d/%0d/%0d/%0d.",
			board.results_checked, board.stamps_seen, board.per_mode[0],
			board.per_mode[1], board.per_mode[2], board.per_mode[3]);
		$display("Payload extremes, suppressed data and disabled output were exercised.");
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("PASS led_data_beacon_pattern_drive_top");
		end else begin
			$display("FAIL led_data_beacon_pattern_drive_top");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ldbpd_pkg.sv
hw/rtl/led_data_beacon_pattern_drive_top.sv
bench/tb_led_data_beacon_pattern_drive_top.sv
